>>> design/ctta_pkg.sv
// Package for the clock-tick time accounting core.
// Holds field widths, register indexes, reset values and charge bucket codes.
// No dependencies.
`timescale 1ns / 1ps

package ctta_pkg;

    // Field widths
    localparam int unsigned IncW     = 32;
    localparam int unsigned ModeW    = 5;
    localparam int unsigned IrqlW    = 5;
    localparam int unsigned QuantW   = 8;
    localparam int unsigned TimeW    = 64;
    localparam int unsigned CntW     = 32;
    localparam int unsigned BucketW  = 3;
    localparam int unsigned MaxIncW  = 31;
    localparam int unsigned AdjW     = 32;
    localparam int unsigned CfgIdxW  = 8;
    localparam int unsigned CfgDataW = 32;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_MAX_INCREMENT     = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_TIME_ADJUSTMENT   = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_QUANTUM_DECREMENT = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_DISPATCH_LEVEL    = 8'd3;

    // Configuration reset values
    localparam logic [MaxIncW-1:0] MAX_INCREMENT_RST     = 31'd100000;
    localparam logic [AdjW-1:0]    TIME_ADJUSTMENT_RST   = 32'd100000;
    localparam logic [QuantW-1:0]  QUANTUM_DECREMENT_RST = 8'd3;
    localparam logic [IrqlW-1:0]   DISPATCH_LEVEL_RST    = 5'd2;

    // Interrupted mode code for user mode
    localparam logic [ModeW-1:0] MODE_USER = 5'h10;

    // Charge bucket codes
    localparam logic [BucketW-1:0] BUCKET_NONE   = 3'd0;
    localparam logic [BucketW-1:0] BUCKET_USER   = 3'd1;
    localparam logic [BucketW-1:0] BUCKET_ISR    = 3'd2;
    localparam logic [BucketW-1:0] BUCKET_DPC    = 3'd3;
    localparam logic [BucketW-1:0] BUCKET_KERNEL = 3'd4;

endpackage

>>> design/clock_tick_time_accounting_core.sv
// Clock-tick time accounting core: top level.
// Depends on ctta_pkg for widths, register indexes and bucket codes.
`timescale 1ns / 1ps

// Usage:
//   Each transfer on the s_ channel is one clock interrupt. Each one yields
//   exactly one transfer on the m_ channel carrying the updated interrupt
//   time, system time, tick count, full-tick flag, charge bucket, quantum
//   (decremented on full ticks only), quantum-end flag and the four processor tick counters.
//   Configuration registers are written through the cfg_ channel, which is
//   always ready; indexes beyond the register list are ignored. Write them
//   only while no interrupt is in flight.
//   Path: from s_ transfer to m_valid through the input register, then the
//   result register. Throughput: one interrupt per cycle while the receiver
//   does not stall; the running accumulators are updated as each interrupt
//   moves from input to result register, so each interrupt sees the state left by the last.
//   Reset (aresetn low, synchronous) clears both stages, all accumulators
//   and the countdown, and restores the register defaults.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more transfer, after which s_ready drops until m_ready.

module clock_tick_time_accounting_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // interrupt channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ctta_pkg::IncW-1:0]           s_time_increment,
    input  logic [ctta_pkg::ModeW-1:0]          s_cpsr_mode,
    input  logic [ctta_pkg::IrqlW-1:0]          s_old_irql,
    input  logic                                s_dpc_active,
    input  logic signed [ctta_pkg::QuantW-1:0]  s_thread_quantum,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ctta_pkg::TimeW-1:0]          m_interrupt_time,
    output logic [ctta_pkg::TimeW-1:0]          m_system_time,
    output logic [ctta_pkg::TimeW-1:0]          m_tick_count,
    output logic                                m_full_tick,
    output logic [ctta_pkg::BucketW-1:0]        m_charge_bucket,
    output logic signed [ctta_pkg::QuantW-1:0]  m_new_quantum,
    output logic                                m_quantum_end,
    output logic [ctta_pkg::CntW-1:0]           m_cpu_user_time,
    output logic [ctta_pkg::CntW-1:0]           m_cpu_kernel_time,
    output logic [ctta_pkg::CntW-1:0]           m_cpu_isr_time,
    output logic [ctta_pkg::CntW-1:0]           m_cpu_dpc_time,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ctta_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [ctta_pkg::CfgDataW-1:0]       cfg_wdata
);

    import ctta_pkg::*;

    // Configuration registers
    logic [MaxIncW-1:0] max_inc_reg;
    logic [AdjW-1:0]    time_adj_reg;
    logic [QuantW-1:0]  quant_dec_reg;
    logic [IrqlW-1:0]   disp_level_reg;

    // Input register
    logic               in_valid_reg;
    logic [IncW-1:0]    in_inc_reg;
    logic [ModeW-1:0]   in_mode_reg;
    logic [IrqlW-1:0]   in_irql_reg;
    logic               in_dpc_reg;
    logic [QuantW-1:0]  in_quant_reg;

    // Running state
    logic [TimeW-1:0]   irq_time_reg;
    logic [IncW-1:0]    countdown_reg;
    logic [TimeW-1:0]   sys_time_reg;
    logic [TimeW-1:0]   tick_reg;
    logic [CntW-1:0]    user_ticks_reg;
    logic [CntW-1:0]    kernel_ticks_reg;
    logic [CntW-1:0]    isr_ticks_reg;
    logic [CntW-1:0]    dpc_ticks_reg;

    // Next values
    logic [TimeW-1:0]   irq_time_next;
    logic [IncW-1:0]    countdown_sub;
    logic [IncW-1:0]    countdown_next;
    logic [TimeW-1:0]   sys_time_next;
    logic [TimeW-1:0]   tick_next;
    logic [CntW-1:0]    user_ticks_next;
    logic [CntW-1:0]    kernel_ticks_next;
    logic [CntW-1:0]    isr_ticks_next;
    logic [CntW-1:0]    dpc_ticks_next;
    logic               full_next;
    logic [BucketW-1:0] bucket_next;
    logic [QuantW-1:0]  quant_dec;
    logic [QuantW-1:0]  quant_next;
    logic               qend_next;

    // Result register valid
    logic               out_valid_reg;

    // Handshake control
    logic               advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign cfg_ready = 1'b1;

    // Take configuration writes; ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_inc_reg    <= MAX_INCREMENT_RST;
            time_adj_reg   <= TIME_ADJUSTMENT_RST;
            quant_dec_reg  <= QUANTUM_DECREMENT_RST;
            disp_level_reg <= DISPATCH_LEVEL_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_MAX_INCREMENT) begin
                max_inc_reg <= cfg_wdata[MaxIncW-1:0];
            end
            if (cfg_index == REG_TIME_ADJUSTMENT) begin
                time_adj_reg <= cfg_wdata[AdjW-1:0];
            end
            if (cfg_index == REG_QUANTUM_DECREMENT) begin
                quant_dec_reg <= cfg_wdata[QuantW-1:0];
            end
            if (cfg_index == REG_DISPATCH_LEVEL) begin
                disp_level_reg <= cfg_wdata[IrqlW-1:0];
            end
        end
    end

    // Capture the interrupt on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_inc_reg   <= s_time_increment;
            in_mode_reg  <= s_cpsr_mode;
            in_irql_reg  <= s_old_irql;
            in_dpc_reg   <= s_dpc_active;
            in_quant_reg <= s_thread_quantum;
        end
    end

    // Add up interrupt time, count down the tick offset, decide whether a full tick completes and decrement the quantum
    always_comb begin
        irq_time_next = irq_time_reg + {{(TimeW-IncW){1'b0}}, in_inc_reg};
        countdown_sub = countdown_reg - in_inc_reg;
        full_next     = (countdown_sub == '0) || countdown_sub[IncW-1];
        quant_dec     = in_quant_reg - quant_dec_reg;
    end

    // Sort the tick into a bucket and bump the matching counters
    always_comb begin
        countdown_next    = countdown_sub;
        sys_time_next     = sys_time_reg;
        tick_next         = tick_reg;
        user_ticks_next   = user_ticks_reg;
        kernel_ticks_next = kernel_ticks_reg;
        isr_ticks_next    = isr_ticks_reg;
        dpc_ticks_next    = dpc_ticks_reg;
        bucket_next       = BUCKET_NONE;
        quant_next        = in_quant_reg;
        qend_next         = 1'b0;
        if (full_next) begin
            countdown_next = countdown_sub + {1'b0, max_inc_reg};
            sys_time_next  = sys_time_reg + {{(TimeW-AdjW){1'b0}}, time_adj_reg};
            tick_next      = tick_reg + {{(TimeW-1){1'b0}}, 1'b1};
            quant_next     = quant_dec;
            qend_next      = (quant_dec == '0) || quant_dec[QuantW-1];
            priority if (in_mode_reg == MODE_USER) begin
                bucket_next     = BUCKET_USER;
                user_ticks_next = user_ticks_reg + {{(CntW-1){1'b0}}, 1'b1};
            end else if (in_irql_reg > disp_level_reg) begin
                bucket_next       = BUCKET_ISR;
                isr_ticks_next    = isr_ticks_reg + {{(CntW-1){1'b0}}, 1'b1};
                kernel_ticks_next = kernel_ticks_reg + {{(CntW-1){1'b0}}, 1'b1};
            end else if (in_irql_reg == disp_level_reg && in_dpc_reg) begin
                bucket_next       = BUCKET_DPC;
                dpc_ticks_next    = dpc_ticks_reg + {{(CntW-1){1'b0}}, 1'b1};
                kernel_ticks_next = kernel_ticks_reg + {{(CntW-1){1'b0}}, 1'b1};
            end else begin
                bucket_next       = BUCKET_KERNEL;
                kernel_ticks_next = kernel_ticks_reg + {{(CntW-1){1'b0}}, 1'b1};
            end
        end
    end

    // Advance the running state once per interrupt
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irq_time_reg     <= '0;
            countdown_reg    <= '0;
            sys_time_reg     <= '0;
            tick_reg         <= '0;
            user_ticks_reg   <= '0;
            kernel_ticks_reg <= '0;
            isr_ticks_reg    <= '0;
            dpc_ticks_reg    <= '0;
        end else if (advance) begin
            irq_time_reg     <= irq_time_next;
            countdown_reg    <= countdown_next;
            sys_time_reg     <= sys_time_next;
            tick_reg         <= tick_next;
            user_ticks_reg   <= user_ticks_next;
            kernel_ticks_reg <= kernel_ticks_next;
            isr_ticks_reg    <= isr_ticks_next;
            dpc_ticks_reg    <= dpc_ticks_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_interrupt_time  <= irq_time_next;
            m_system_time     <= sys_time_next;
            m_tick_count      <= tick_next;
            m_full_tick       <= full_next;
            m_charge_bucket   <= bucket_next;
            m_new_quantum     <= quant_next;
            m_quantum_end     <= qend_next;
            m_cpu_user_time   <= user_ticks_next;
            m_cpu_kernel_time <= kernel_ticks_next;
            m_cpu_isr_time    <= isr_ticks_next;
            m_cpu_dpc_time    <= dpc_ticks_next;
        end
    end

endmodule

>>> design/ctta_checker.sv
// Port-level checker for the clock-tick time accounting core, with its bind.
// Depends on ctta_pkg for widths and bucket codes.
`timescale 1ns / 1ps

module ctta_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [ctta_pkg::TimeW-1:0]          m_interrupt_time,
    input logic                                m_full_tick,
    input logic [ctta_pkg::BucketW-1:0]        m_charge_bucket,
    input logic                                m_quantum_end
);

    import ctta_pkg::*;

    // A stalled result keeps its valid and its interrupt time
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_interrupt_time))
        else $error("stalled result changed");

    // Nothing is shown in the cycle after reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

    // A partial tick charges no bucket and ends no quantum
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_full_tick |-> m_charge_bucket == BUCKET_NONE && !m_quantum_end)
        else $error("partial tick charged or ended quantum");

    // A full tick always lands in a real bucket
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_full_tick |->
            m_charge_bucket == BUCKET_USER || m_charge_bucket == BUCKET_ISR ||
            m_charge_bucket == BUCKET_DPC  || m_charge_bucket == BUCKET_KERNEL)
        else $error("full tick without a bucket");

endmodule

bind clock_tick_time_accounting_core ctta_checker u_ctta_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_interrupt_time (m_interrupt_time),
    .m_full_tick      (m_full_tick),
    .m_charge_bucket  (m_charge_bucket),
    .m_quantum_end    (m_quantum_end)
);
